// ===== src/assert_macros.svh =====
// assertion helpers for the fade envelope block
// clocked on clk_i, muted while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication with antecedent and consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lfe_pkg.sv =====
// shared constants and phase codes for the fade envelope block
// no dependencies
`timescale 1ns / 1ps

package lfe_pkg;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned COLOUR_W = 32;
  localparam int unsigned LANE_W   = 8;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_FADEIN  = 2'd1;
  localparam logic [1:0] PH_HOLD    = 2'd2;
  localparam logic [1:0] PH_FADEOUT = 2'd3;

  localparam logic [2:0] REG_FADE_IN    = 3'd0;
  localparam logic [2:0] REG_HOLD       = 3'd1;
  localparam logic [2:0] REG_FADE_OUT   = 3'd2;
  localparam logic [2:0] REG_DEST       = 3'd3;
  localparam logic [2:0] REG_ORIGIN_ONE = 3'd4;
  localparam logic [2:0] REG_ORIGIN_TWO = 3'd5;
  localparam logic [2:0] REG_ORIGIN_AMB = 3'd6;

endpackage

// ===== src/lfe_div.sv =====
// restoring divider for the q0.16 blend fraction: (num << 16) / den, num < den
// one quotient bit per cycle while busy; uses lfe_pkg
`timescale 1ns / 1ps

module lfe_div import lfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] num_i,
  input  logic [TIME_W-1:0] den_i,
  output logic              done_o,
  output logic [TIME_W-1:0] quot_o
);

  logic [TIME_W-1:0]         rem_q;
  logic [TIME_W-1:0]         den_q;
  logic [TIME_W-1:0]         quot_q;
  logic [$clog2(TIME_W)-1:0] cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [TIME_W:0]           rem2;
  logic                      ge;
  logic [TIME_W:0]           rem_n;

  assign rem2  = {rem_q, 1'b0};
  assign ge    = rem2 >= {1'b0, den_q};
  assign rem_n = ge ? (rem2 - {1'b0, den_q}) : rem2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // pulse after the last quotient bit
      done_q <= !start_i && busy_q && (cnt_q == '1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= num_i;
        den_q  <= den_i;
      end else if (busy_q) begin
        // remainder stays below den, so the top bit is always clear
        rem_q  <= rem_n[TIME_W-1:0];
        quot_q <= {quot_q[TIME_W-2:0], ge};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/light_fade_envelope.sv =====
// Fade envelope for two lights and an ambient colour, RGBA8 each. A start
// item (tuser high) arms fade-in; each tick item (tuser low) advances the
// time by tdata ticks unless idle and yields one result item with the three
// colours and the phase. Start items and idle ticks pass S_IDLE, S_EVAL and
// S_DONE; ticks that hold, end the envelope or hit a phase end add S_PHASE;
// a blended tick adds the fraction divider (S_DIV) and 12 passes through a
// single 9x16 lane multiplier (S_LERP). A stalled output adds its wait. The
// input side is ready again only once the result is in the output register.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module light_fade_envelope import lfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] delta_ticks
  input  logic         s_axis_tuser,   // [0] req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // light_one_out, light_two_out, ambient_out,
                                       // phase_out, zero fill
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_PHASE, S_DIV, S_LERP, S_DONE
  } state_e;

  state_e               state_q;
  logic                 req_q;
  logic [LANE_W-1:0]    delta_q;
  logic [TIME_W-1:0]    fin_ticks_q, hold_ticks_q, fout_ticks_q;
  logic [COLOUR_W-1:0]  dest_q, org_one_q, org_two_q, org_amb_q;
  logic [1:0]           phase_q;
  logic [TIME_W-1:0]    elapsed_q, fin_el_q, fout_el_q;
  logic [COLOUR_W-1:0]  colour_q [3];
  logic [TIME_W+1:0]    end_hold_q, end_out_q;
  logic                 dir_q;     // low: origin toward dest, high: back to origin
  logic [TIME_W-1:0]    frac_q;
  logic [1:0]           col_q, lane_q;
  logic                 m_valid_q;
  logic [103:0]         m_data_q;

  logic                 div_start;
  logic [TIME_W-1:0]    div_num, div_den;
  logic                 div_done;
  logic [TIME_W-1:0]    div_quot;

  logic [TIME_W:0]      elapsed_sum, fin_sum, fout_sum;
  logic [TIME_W-1:0]    elapsed_d, fin_el_d, fout_el_d;

  logic [COLOUR_W-1:0]  org_sel;
  logic [LANE_W-1:0]    org_lane, dest_lane, lane_a, lane_b;
  logic signed [8:0]    lane_diff;
  logic signed [16:0]   frac_s;
  logic signed [25:0]   prod;
  logic signed [9:0]    step;
  logic signed [9:0]    lane_sum;
  logic                 out_free;

  assign elapsed_sum = {1'b0, elapsed_q} + {{(TIME_W-LANE_W+1){1'b0}}, delta_q};
  assign fin_sum     = {1'b0, fin_el_q} + {{(TIME_W-LANE_W+1){1'b0}}, delta_q};
  assign fout_sum    = {1'b0, fout_el_q} + {{(TIME_W-LANE_W+1){1'b0}}, delta_q};
  assign elapsed_d   = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
  assign fin_el_d    = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
  assign fout_el_d   = fout_sum[TIME_W] ? '1 : fout_sum[TIME_W-1:0];

  always_comb begin
    unique case (col_q)
      2'd0:    org_sel = org_one_q;
      2'd1:    org_sel = org_two_q;
      default: org_sel = org_amb_q;
    endcase
  end

  // shared lane blend: a + round((b - a) * f / 65536)
  assign org_lane  = org_sel[lane_q*LANE_W +: LANE_W];
  assign dest_lane = dest_q[lane_q*LANE_W +: LANE_W];
  assign lane_a    = dir_q ? dest_lane : org_lane;
  assign lane_b    = dir_q ? org_lane : dest_lane;
  assign lane_diff = $signed({1'b0, lane_b}) - $signed({1'b0, lane_a});
  assign frac_s    = $signed({1'b0, frac_q});
  assign prod      = lane_diff * frac_s;
  assign step      = 10'((prod + 26'sd32768) >>> 16);
  assign lane_sum  = $signed({2'b00, lane_a}) + step;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = fin_el_d;
    div_den   = fin_ticks_q;
    if (state_q == S_PHASE) begin
      if ({2'b00, elapsed_q} < {2'b00, fin_ticks_q}) begin
        div_start = fin_el_d < fin_ticks_q;
      end else if ({2'b00, elapsed_q} >= end_hold_q && {2'b00, elapsed_q} < end_out_q) begin
        div_num   = fout_el_d;
        div_den   = fout_ticks_q;
        div_start = fout_el_d < fout_ticks_q;
      end
    end
  end

  lfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      m_valid_q    <= 1'b0;
      phase_q      <= PH_IDLE;
      elapsed_q    <= '0;
      fin_el_q     <= '0;
      fout_el_q    <= '0;
      colour_q[0]  <= '0;
      colour_q[1]  <= '0;
      colour_q[2]  <= '0;
      fin_ticks_q  <= '0;
      hold_ticks_q <= '0;
      fout_ticks_q <= '0;
      dest_q       <= '0;
      org_one_q    <= '0;
      org_two_q    <= '0;
      org_amb_q    <= '0;
      col_q        <= '0;
      lane_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_FADE_IN:    fin_ticks_q  <= cfg_data_i[TIME_W-1:0];
          REG_HOLD:       hold_ticks_q <= cfg_data_i[TIME_W-1:0];
          REG_FADE_OUT:   fout_ticks_q <= cfg_data_i[TIME_W-1:0];
          REG_DEST:       dest_q       <= cfg_data_i;
          REG_ORIGIN_ONE: org_one_q    <= cfg_data_i;
          REG_ORIGIN_TWO: org_two_q    <= cfg_data_i;
          REG_ORIGIN_AMB: org_amb_q    <= cfg_data_i;
          default: ;
        endcase
      end

      // load wins over the drain of the previous item
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req_q   <= s_axis_tuser;
            delta_q <= s_axis_tdata;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          end_hold_q <= {2'b00, fin_ticks_q} + {2'b00, hold_ticks_q};
          end_out_q  <= {2'b00, fin_ticks_q} + {2'b00, hold_ticks_q} + {2'b00, fout_ticks_q};
          if (req_q) begin
            phase_q   <= PH_FADEIN;
            elapsed_q <= '0;
            fin_el_q  <= '0;
            fout_el_q <= '0;
            state_q   <= S_DONE;
          end else if (phase_q == PH_IDLE) begin
            state_q <= S_DONE;
          end else begin
            elapsed_q <= elapsed_d;
            state_q   <= S_PHASE;
          end
        end
        S_PHASE: begin
          col_q  <= '0;
          lane_q <= '0;
          if ({2'b00, elapsed_q} < {2'b00, fin_ticks_q}) begin
            phase_q  <= PH_FADEIN;
            fin_el_q <= fin_el_d;
            dir_q    <= 1'b0;
            if (fin_el_d >= fin_ticks_q) begin
              colour_q[0] <= dest_q;
              colour_q[1] <= dest_q;
              colour_q[2] <= dest_q;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_DIV;
            end
          end else if ({2'b00, elapsed_q} < end_hold_q) begin
            phase_q     <= PH_HOLD;
            colour_q[0] <= dest_q;
            colour_q[1] <= dest_q;
            colour_q[2] <= dest_q;
            state_q     <= S_DONE;
          end else if ({2'b00, elapsed_q} < end_out_q) begin
            phase_q   <= PH_FADEOUT;
            fout_el_q <= fout_el_d;
            dir_q     <= 1'b1;
            if (fout_el_d >= fout_ticks_q) begin
              colour_q[0] <= org_one_q;
              colour_q[1] <= org_two_q;
              colour_q[2] <= org_amb_q;
              state_q     <= S_DONE;
            end else begin
              state_q <= S_DIV;
            end
          end else begin
            // envelope finished: back to resting colours
            phase_q     <= PH_IDLE;
            elapsed_q   <= '0;
            fin_el_q    <= '0;
            fout_el_q   <= '0;
            colour_q[0] <= org_one_q;
            colour_q[1] <= org_two_q;
            colour_q[2] <= org_amb_q;
            state_q     <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac_q  <= div_quot;
            state_q <= S_LERP;
          end
        end
        S_LERP: begin
          colour_q[col_q][lane_q*LANE_W +: LANE_W] <= lane_sum[LANE_W-1:0];
          lane_q <= lane_q + 1'b1;
          if (lane_q == 2'd3) begin
            col_q <= col_q + 1'b1;
            if (col_q == 2'd2) begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_data_q  <= {6'd0, phase_q, colour_q[2], colour_q[1], colour_q[0]};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
    "input accepted while previous item still in work")
  `ASSERT_IMPLY(a_div_only_in_div, div_done, state_q == S_DIV,
    "divider finished outside the divide step")
  `ASSERT_ALWAYS(a_idle_counters_clear, phase_q != PH_IDLE || (elapsed_q == '0 &&
    fin_el_q == '0 && fout_el_q == '0), "time counters not clear while idle")
  `ASSERT_NEXT(a_result_loaded, state_q == S_DONE && out_free, m_axis_tvalid,
    "result not presented after completion")

endmodule
